@@ rtl/lruc_pkg.sv @@
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared types and codes of the LRU key-value cache: request opcodes,
// register map and the tags that ride with the tokens along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package lruc_pkg;

	// request opcodes
	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	// register map (register index is paddr[2])
	localparam int   ADDR_BITS = 3;
	localparam logic REG_CAP   = 1'b0;

	localparam int              CAP_BITS  = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	// lookup token: walks the chain and picks up the first matching entry
	typedef struct packed {
		logic active;
		logic hit;
	} srch_tag_t;

	// shift token: carries the displaced entry one cell down per cycle
	typedef struct packed {
		logic active;
		logic valid;
	} sh_tag_t;

endpackage

`default_nettype wire

@@ rtl/lruc_cell.sv @@
// ----------------------------------------------------------------------------
// lruc_cell
// One slot of the recency-ordered entry list. Compares a passing lookup
// token against its key, and on a passing shift token takes the entry from
// its upper neighbor and hands its own entry down.
// ----------------------------------------------------------------------------
`default_nettype none

module lruc_cell
	import lruc_pkg::*;
#(
	parameter int KEY_BITS   = 16,
	parameter int VALUE_BITS = 16,
	parameter int IDX_W      = 4,
	parameter int CELL_IDX   = 0
) (
	input  wire                    clk,
	input  wire                    arst_n,
	// lookup token
	input  wire  [KEY_BITS-1:0]    srch_key,
	input  wire  srch_tag_t        srch_in,
	input  wire  [IDX_W-1:0]       srch_idx_in,
	input  wire  [VALUE_BITS-1:0]  srch_val_in,
	output srch_tag_t              srch_out,
	output logic [IDX_W-1:0]       srch_idx_out,
	output logic [VALUE_BITS-1:0]  srch_val_out,
	// shift token
	input  wire  sh_tag_t          sh_in,
	input  wire  [IDX_W-1:0]       sh_stop_in,
	input  wire  [KEY_BITS-1:0]    sh_key_in,
	input  wire  [VALUE_BITS-1:0]  sh_val_in,
	output sh_tag_t                sh_out,
	output logic [IDX_W-1:0]       sh_stop_out,
	output logic [KEY_BITS-1:0]    sh_key_out,
	output logic [VALUE_BITS-1:0]  sh_val_out
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	srch_tag_t             srch_tag_q;
	logic [IDX_W-1:0]      srch_idx_q;
	logic [VALUE_BITS-1:0] srch_val_q;

	sh_tag_t               sh_tag_q;
	logic [IDX_W-1:0]      sh_stop_q;
	logic [KEY_BITS-1:0]   sh_key_q;
	logic [VALUE_BITS-1:0] sh_val_q;

	logic match;
	logic take_hit;
	logic pass_on;

	assign match    = valid_q && (key_q == srch_key);
	assign take_hit = srch_in.active && !srch_in.hit && match;
	// the stop cell absorbs the carried entry, its old one is dropped
	assign pass_on  = sh_in.active && (sh_stop_in != MY_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			srch_tag_q <= '0;
			sh_tag_q   <= '0;
		end else begin
			if (sh_in.active) begin
				valid_q <= sh_in.valid;
			end
			srch_tag_q.active <= srch_in.active;
			srch_tag_q.hit    <= srch_in.active && (srch_in.hit || match);
			sh_tag_q.active   <= pass_on;
			sh_tag_q.valid    <= valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (sh_in.active) begin
			key_q <= sh_key_in;
			val_q <= sh_val_in;
		end
		if (take_hit) begin
			srch_idx_q <= MY_IDX;
			srch_val_q <= val_q;
		end else begin
			srch_idx_q <= srch_idx_in;
			srch_val_q <= srch_val_in;
		end
		sh_stop_q <= sh_stop_in;
		sh_key_q  <= key_q;
		sh_val_q  <= val_q;
	end

	assign srch_out     = srch_tag_q;
	assign srch_idx_out = srch_idx_q;
	assign srch_val_out = srch_val_q;
	assign sh_out       = sh_tag_q;
	assign sh_stop_out  = sh_stop_q;
	assign sh_key_out   = sh_key_q;
	assign sh_val_out   = sh_val_q;

endmodule

`default_nettype wire

@@ rtl/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement,
// kept as a recency-ordered chain of cells (cell 0 most recent).
//
//   channel  signals                                   direction
//   req      req_valid, req_stall, op, key, value      into the block
//   rsp      rsp_valid, rsp_stall, hit, read_value     out of the block
//   cfg      psel, penable, pwrite, paddr, pwdata,     APB register port
//            prdata, pready
//
// Each item passes in order through the search state, where the lookup token
// clears the chain, the decision state, which on a set or a get hit launches
// the shift token that moves the touched entry to the front, and the idle
// state, where the next beat is taken. A get beat is registered out of the
// decision state. The shift of one item overlaps the lookup of the next.
// Reset clears all valid bits at once. A stalled rsp beat holds the block in
// its decision cycle only for a get; sets go on.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache
	import lruc_pkg::*;
#(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 16,
	parameter int VALUE_BITS = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	// config
	input  wire                   psel,
	input  wire                   penable,
	input  wire                   pwrite,
	input  wire  [ADDR_BITS-1:0]  paddr,
	input  wire  [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// requests
	input  wire                   req_valid,
	output logic                  req_stall,
	input  wire                   op,
	input  wire  [KEY_BITS-1:0]   key,
	input  wire  [VALUE_BITS-1:0] value,
	// responses
	output logic                  rsp_valid,
	input  wire                   rsp_stall,
	output logic                  hit,
	output logic [VALUE_BITS-1:0] read_value
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;

	logic [1:0]            state_q;
	logic [CAP_BITS-1:0]   cap_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      cap_eff;

	logic                  op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	logic                  res_hit_q;
	logic [IDX_W-1:0]      res_idx_q;
	logic [VALUE_BITS-1:0] res_val_q;

	srch_tag_t             srch_q;
	sh_tag_t               sh_q;
	logic [IDX_W-1:0]      sh_stop_q;
	logic [KEY_BITS-1:0]   sh_key_q;
	logic [VALUE_BITS-1:0] sh_val_q;

	logic                  rsp_valid_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] rd_q;

	logic                  cfg_wr;
	logic                  accept;
	logic                  res_arrive;
	logic                  slot_free;
	logic                  go;
	logic                  send_rsp;
	logic                  launch_sh;
	logic                  do_fill;
	logic [IDX_W-1:0]      stop_idx;

	srch_tag_t             srch_tag [ENTRIES+1];
	logic [IDX_W-1:0]      srch_idx [ENTRIES+1];
	logic [VALUE_BITS-1:0] srch_val [ENTRIES+1];
	sh_tag_t               sh_tag   [ENTRIES+1];
	logic [IDX_W-1:0]      sh_stop  [ENTRIES+1];
	logic [KEY_BITS-1:0]   sh_key   [ENTRIES+1];
	logic [VALUE_BITS-1:0] sh_val   [ENTRIES+1];

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAP);
	assign prdata = (paddr[2] == REG_CAP) ? 32'(cap_q) : '0;

	always_comb begin
		priority if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (cap_q > ENTRIES) begin
			cap_eff = CNT_W'(ENTRIES);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end

	// control
	assign req_stall  = (state_q != ST_IDLE);
	assign accept     = req_valid && (state_q == ST_IDLE);
	assign res_arrive = srch_tag[ENTRIES].active;
	assign slot_free  = !rsp_valid_q || !rsp_stall;
	assign go         = (state_q == ST_DECIDE) && ((op_q == OP_SET) || slot_free);
	assign send_rsp   = go && (op_q == OP_GET);
	assign launch_sh  = go && ((op_q == OP_SET) || res_hit_q);
	assign do_fill    = go && (op_q == OP_SET) && !res_hit_q && (count_q < cap_eff);

	always_comb begin
		priority if (res_hit_q) begin
			stop_idx = res_idx_q;
		end else if (count_q < cap_eff) begin
			stop_idx = IDX_W'(count_q);
		end else begin
			// full: the tail entry is the least recent one and gets dropped
			stop_idx = IDX_W'(count_q - CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			srch_q      <= '0;
			sh_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				cap_q <= pwdata[CAP_BITS-1:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (res_arrive) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (do_fill) begin
				count_q <= count_q + CNT_W'(1);
			end
			srch_q.active <= accept;
			srch_q.hit    <= 1'b0;
			sh_q.active   <= launch_sh;
			sh_q.valid    <= 1'b1;
			if (send_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			key_q   <= key;
			value_q <= value;
		end
		if (res_arrive) begin
			res_hit_q <= srch_tag[ENTRIES].hit;
			res_idx_q <= srch_idx[ENTRIES];
			res_val_q <= srch_val[ENTRIES];
		end
		if (launch_sh) begin
			sh_stop_q <= stop_idx;
			sh_key_q  <= key_q;
			sh_val_q  <= (op_q == OP_SET) ? value_q : res_val_q;
		end
		if (send_rsp) begin
			hit_q <= res_hit_q;
			rd_q  <= res_hit_q ? res_val_q : '0;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign hit        = hit_q;
	assign read_value = rd_q;

	// cell chain
	assign srch_tag[0] = srch_q;
	assign srch_idx[0] = '0;
	assign srch_val[0] = '0;
	assign sh_tag[0]   = sh_q;
	assign sh_stop[0]  = sh_stop_q;
	assign sh_key[0]   = sh_key_q;
	assign sh_val[0]   = sh_val_q;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lruc_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.IDX_W      (IDX_W),
			.CELL_IDX   (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.srch_key     (key_q),
			.srch_in      (srch_tag[i]),
			.srch_idx_in  (srch_idx[i]),
			.srch_val_in  (srch_val[i]),
			.srch_out     (srch_tag[i+1]),
			.srch_idx_out (srch_idx[i+1]),
			.srch_val_out (srch_val[i+1]),
			.sh_in        (sh_tag[i]),
			.sh_stop_in   (sh_stop[i]),
			.sh_key_in    (sh_key[i]),
			.sh_val_in    (sh_val[i]),
			.sh_out       (sh_tag[i+1]),
			.sh_stop_out  (sh_stop[i+1]),
			.sh_key_out   (sh_key[i+1]),
			.sh_val_out   (sh_val[i+1])
		);
	end

	// a shift always stops inside the chain, never past its last cell
	a_shift_stops: assert property (@(posedge clk) disable iff (!arst_n)
		!sh_tag[ENTRIES].active)
		else $error("shift token ran off the chain");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count above ENTRIES");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("entry count moved by more than one");

	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		srch_tag[ENTRIES].active |-> (state_q == ST_SEARCH))
		else $error("lookup result outside search phase");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_DECIDE))
		else $error("response beat without a decision");

endmodule

`default_nettype wire
